[hdl/thm_pkg.sv]
package thm_pkg;

	// Default number of task slots held in the table.
	localparam int SLOTS_DEF = 16;

	// A tick walks at most this many slots, one result per slot.
	localparam int WALK_MAX = 16;

	// Item kinds.
	localparam logic [1:0] KIND_REGISTER = 2'd0;
	localparam logic [1:0] KIND_CHECKIN  = 2'd1;
	localparam logic [1:0] KIND_TICK     = 2'd2;

	// Result status codes.
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_REQUEST  = 3'd1;
	localparam logic [2:0] STATUS_FAULT    = 3'd2;
	localparam logic [2:0] STATUS_UNKNOWN  = 3'd3;
	localparam logic [2:0] STATUS_HALTED   = 3'd4;

	// One input beat.
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [31:0] timeout_ms;
		logic [15:0] elapsed_ms;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [3:0]  result_slot;
		logic        armed;
		logic [2:0]  status;
		logic [31:0] peak_wait_ms;
		logic        last;
	} result_t;

endpackage

[hdl/task_heartbeat_monitor.sv]
// Heartbeat watchdog over a table of task slots. A register beat arms a slot with its
// timeout, a check-in beat clears the slot's counters, and a tick beat ages every armed
// slot and returns one result per slot (the first min(SLOTS,16) slots) in slot order, the
// final one marked with last. Register and check-in beats pass through the read and emit
// states; a tick visits read and emit for an unarmed slot (or every slot once halted) and
// read, since, wait and emit for an armed slot. This order comes from the single-ported
// slot memory with its registered read and from the one saturating adder and comparator,
// which serve the since-check-in count and the wait count in turn. A stall on the result
// side holds the emit state. The block takes no new beat until the last result of the
// current one has been loaded into the output register. A timeout fault halts the block
// until reset; slot contents are undefined until a slot is registered.
module task_heartbeat_monitor #(
	parameter int SLOTS = thm_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  thm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output thm_pkg::result_t result
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WALK  = (SLOTS < thm_pkg::WALK_MAX) ? SLOTS : thm_pkg::WALK_MAX;
	localparam logic [3:0] LAST_SLOT = 4'(WALK - 1);
	localparam logic [6:0] SLOTS_W7  = 7'(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SINCE,
		S_WAIT,
		S_EMIT
	} state_t;

	// One row of the slot memory.
	typedef struct packed {
		logic [31:0] tmo_ms;
		logic [31:0] since_ms;
		logic [31:0] wait_ms;
		logic [31:0] peak_ms;
		logic        awaiting;
	} row_t;

	state_t           state_q;
	logic [1:0]       kind_q;
	logic [3:0]       slot_q;
	logic [31:0]      tmo_in_q;
	logic [15:0]      elapsed_q;
	logic [SLOTS-1:0] armed_q;
	logic             halted_q;
	logic             result_valid_q;
	thm_pkg::result_t result_q;

	row_t             mem [SLOTS];
	row_t             rd_q;
	logic [31:0]      since_q;
	logic             since_gt_q;
	logic [31:0]      wait_q;
	logic             wait_gt_q;

	logic [IDX_W+3:0] slot_ext;
	logic [IDX_W-1:0] idx;
	logic             slot_ok;
	logic             armed_cur;
	logic             out_free;

	logic [31:0]      add_a;
	logic [32:0]      add_sum;
	logic [31:0]      sat_sum;
	logic             sum_gt_tmo;

	logic             mem_we;
	row_t             wr_row;
	logic             set_halt;
	logic             set_arm;
	thm_pkg::result_t res_d;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Slot index into the table, and whether it names a slot that exists.
	assign slot_ext  = {{IDX_W{1'b0}}, slot_q};
	assign idx       = slot_ext[IDX_W-1:0];
	assign slot_ok   = ({3'b000, slot_q} < SLOTS_W7);
	assign armed_cur = slot_ok ? armed_q[idx] : 1'b0;
	assign out_free  = !result_valid_q || !result_stall;

	// Shared saturating adder and timeout comparator: since-check-in first, then wait.
	assign add_a      = (state_q == S_SINCE) ? rd_q.since_ms : rd_q.wait_ms;
	assign add_sum    = {1'b0, add_a} + {17'b0, elapsed_q};
	assign sat_sum    = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
	assign sum_gt_tmo = (sat_sum > rd_q.tmo_ms);

	// Result and write-back for the slot in hand.
	always_comb begin
		mem_we   = 1'b0;
		wr_row   = rd_q;
		set_halt = 1'b0;
		set_arm  = 1'b0;
		res_d.result_slot  = slot_q;
		res_d.armed        = armed_cur;
		res_d.status       = thm_pkg::STATUS_OK;
		res_d.peak_wait_ms = armed_cur ? rd_q.peak_ms : 32'd0;
		res_d.last         = 1'b1;
		if (kind_q == thm_pkg::KIND_TICK) begin
			res_d.last = (slot_q == LAST_SLOT);
			if (halted_q) begin
				res_d.status = thm_pkg::STATUS_HALTED;
			end else if (armed_cur) begin
				wr_row.since_ms = since_q;
				if (rd_q.awaiting) begin
					wr_row.wait_ms = wait_q;
					if (wait_q > rd_q.peak_ms) begin
						wr_row.peak_ms = wait_q;
					end
					if (wait_gt_q) begin
						set_halt     = 1'b1;
						res_d.status = thm_pkg::STATUS_FAULT;
					end
				end else if (since_gt_q) begin
					wr_row.wait_ms  = 32'd0;
					wr_row.awaiting = 1'b1;
					res_d.status    = thm_pkg::STATUS_REQUEST;
				end
				res_d.peak_wait_ms = wr_row.peak_ms;
				mem_we = (state_q == S_EMIT) && out_free;
			end
		end else begin
			if (halted_q) begin
				res_d.status = thm_pkg::STATUS_HALTED;
			end else if (!slot_ok) begin
				res_d.armed        = 1'b0;
				res_d.status       = thm_pkg::STATUS_UNKNOWN;
				res_d.peak_wait_ms = 32'd0;
			end else if (kind_q == thm_pkg::KIND_REGISTER) begin
				wr_row.tmo_ms      = tmo_in_q;
				wr_row.since_ms    = 32'd0;
				wr_row.wait_ms     = 32'd0;
				wr_row.peak_ms     = 32'd0;
				wr_row.awaiting    = 1'b0;
				res_d.armed        = 1'b1;
				res_d.peak_wait_ms = 32'd0;
				set_arm = (state_q == S_EMIT) && out_free;
				mem_we  = (state_q == S_EMIT) && out_free;
			end else if (!armed_cur) begin
				res_d.status = thm_pkg::STATUS_UNKNOWN;
			end else begin
				wr_row.since_ms = 32'd0;
				wr_row.wait_ms  = 32'd0;
				wr_row.awaiting = 1'b0;
				mem_we = (state_q == S_EMIT) && out_free;
			end
		end
	end

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx] <= wr_row;
		end
		if (state_q == S_READ) begin
			rd_q <= mem[idx];
		end
		if (state_q == S_SINCE) begin
			since_q    <= sat_sum;
			since_gt_q <= sum_gt_tmo;
		end
		if (state_q == S_WAIT) begin
			wait_q    <= sat_sum;
			wait_gt_q <= sum_gt_tmo;
		end
	end

	// Sequencer with the armed flags, halt flag and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			armed_q        <= '0;
			halted_q       <= 1'b0;
			result_valid_q <= 1'b0;
			kind_q         <= thm_pkg::KIND_REGISTER;
			slot_q         <= 4'd0;
			tmo_in_q       <= 32'd0;
			elapsed_q      <= 16'd0;
			result_q       <= '0;
		end else begin
			// The emit state reloads the output register itself.
			if (result_valid_q && !result_stall && state_q != S_EMIT) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						kind_q    <= item.kind;
						tmo_in_q  <= item.timeout_ms;
						elapsed_q <= item.elapsed_ms;
						if (item.kind == thm_pkg::KIND_TICK) begin
							slot_q  <= 4'd0;
							state_q <= S_READ;
						end else if (item.kind == thm_pkg::KIND_REGISTER ||
								item.kind == thm_pkg::KIND_CHECKIN) begin
							slot_q  <= item.slot;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (kind_q == thm_pkg::KIND_TICK && armed_cur && !halted_q) begin
						state_q <= S_SINCE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SINCE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						result_q       <= res_d;
						result_valid_q <= 1'b1;
						if (set_halt) begin
							halted_q <= 1'b1;
						end
						if (set_arm) begin
							armed_q[idx] <= 1'b1;
						end
						if (kind_q == thm_pkg::KIND_TICK && slot_q != LAST_SLOT) begin
							slot_q  <= slot_q + 4'd1;
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
